@@ rtl/core/smf_pkg.sv @@
// shared types and constants of the sliding median filter
package smf_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 6;
    localparam int WIDTH_MIN      = 3;
    localparam int WIDTH_CAP      = 32;
    localparam int MAX_WINDOW_DEF = 32;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic    vld;
        t_sample val;
    } t_link;

endpackage

@@ rtl/core/smf_sort_cell.sv @@
// one cell of the systolic insertion sorter, keeps the smaller value and passes the larger on
module smf_sort_cell
    import smf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_link i_in,
    output t_link o_out,
    output t_sample o_val
);

    logic    r_vld;
    t_sample r_val;
    t_link   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld     <= 1'b0;
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= i_in.vld && r_vld;
            if (i_in.vld) begin
                if (!r_vld) begin
                    r_vld <= 1'b1;
                    r_val <= i_in.val;
                end else if (i_in.val < r_val) begin
                    r_val     <= i_in.val;
                    r_out.val <= r_val;
                end else begin
                    r_out.val <= i_in.val;
                end
            end
        end
    end

    assign o_out = r_out;
    assign o_val = r_val;

endmodule

@@ rtl/core/smf_window.sv @@
// shift line of recent samples, newest at tap zero, with one indexed read
module smf_window
    import smf_pkg::*;
#(
    parameter int DEPTH = MAX_WINDOW_DEF,
    parameter int IW    = $clog2(MAX_WINDOW_DEF)
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  t_sample       i_sample,
    input  logic [IW-1:0] i_rd_idx,
    output t_sample       o_rd_data
);

    t_sample r_taps [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < DEPTH; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    assign o_rd_data = r_taps[i_rd_idx];

endmodule

@@ rtl/core/sliding_median_filter_unit.sv @@
// sliding median filter top level: window line, sorter cell chain and sequencer
// one sample beat is taken when idle; it releases 0..15 results, the final beat all pending ones
// each result (k window samples in range) goes through a check state, k beats fed into
// the sorter chain, a drain state until the chain settles and an output state that waits while held
// synchronous active-low reset clears counters, sorter valid bits and output valid,
// and sets the width to 5; window samples are not cleared
module sliding_median_filter_unit
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_window_width,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_sample          i_sample_value,
    input  logic             i_stream_end,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_sample          o_median_value,
    output logic             o_final_output
);

    localparam int SORT_N = (MAX_WINDOW < WIDTH_CAP) ? MAX_WINDOW : WIDTH_CAP;
    localparam int IW     = $clog2(MAX_WINDOW);
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int KW     = $clog2(SORT_N + 1);
    localparam int SIW    = $clog2(SORT_N);
    localparam int AW     = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam logic [CFG_W-1:0] W_CAP = CFG_W'(SORT_N);
    localparam logic [CFG_W-1:0] W_MIN = CFG_W'(WIDTH_MIN);
    localparam logic [CW-1:0]    SEEN_MAX = CW'(MAX_WINDOW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_FEED  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       r_state;
    logic [CFG_W-1:0] r_width;
    logic [CW-1:0]    r_seen;
    logic [CW-1:0]    r_pend;
    logic             r_last;
    logic             r_final;
    logic [IW-1:0]    r_off;
    logic [IW-1:0]    r_hi;
    logic [KW-1:0]    r_k;
    logic             r_feed_vld;
    t_sample          r_feed_val;
    logic             r_o_valid;
    t_sample          r_o_median;
    logic             r_o_final;

    logic [CW-1:0]    n_seen;
    logic [CW-1:0]    n_pend;
    logic [CW:0]      pend_inc;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] half_w;
    logic [CFG_W-1:0] lag_w;
    logic [AW-1:0]    pend_x;
    logic [AW-1:0]    seen_x;
    logic [AW-1:0]    lag_x;
    logic [AW-1:0]    back_x;
    logic [AW-1:0]    up_x;
    logic [AW-1:0]    hi_x;
    logic [AW-1:0]    lo_x;
    logic             emit_go;
    logic             in_acc;
    logic             sort_clear;
    logic             chain_busy;
    logic [SIW-1:0]   mid_idx;
    t_sample          win_rd;

    t_link   link     [SORT_N+1];
    t_sample cell_val [SORT_N];

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign sort_clear = (r_state == ST_CHECK);

    // effective window width, half and lag
    always_comb begin
        eff_w = r_width;
        if (eff_w < W_MIN) eff_w = W_MIN;
        if (eff_w > W_CAP) eff_w = W_CAP;
        half_w = eff_w >> 1;
        lag_w  = eff_w - 6'd1 - half_w;
    end

    // counters after a new sample
    always_comb begin
        n_seen   = (r_seen < SEEN_MAX) ? r_seen + 1'b1 : r_seen;
        pend_inc = {1'b0, r_pend} + 1'b1;
        n_pend   = (pend_inc > {1'b0, n_seen}) ? n_seen : pend_inc[CW-1:0];
    end

    // window bounds of the oldest pending result
    always_comb begin
        pend_x  = AW'(r_pend);
        seen_x  = AW'(r_seen);
        lag_x   = AW'(lag_w);
        back_x  = pend_x - 1'b1;
        up_x    = back_x + AW'(half_w);
        hi_x    = (up_x < seen_x) ? up_x : seen_x - 1'b1;
        lo_x    = (back_x >= lag_x) ? back_x - lag_x : '0;
        emit_go = r_last ? (r_pend != '0) : (pend_x > lag_x);
    end

    always_comb begin
        chain_busy = r_feed_vld;
        for (int i = 1; i <= SORT_N; i++) begin
            chain_busy = chain_busy | link[i].vld;
        end
    end

    assign mid_idx = SIW'(r_k >> 1);

    smf_window #(
        .DEPTH (MAX_WINDOW),
        .IW    (IW)
    ) u_window (
        .i_clk     (i_clk),
        .i_shift   (in_acc),
        .i_sample  (i_sample_value),
        .i_rd_idx  (r_off),
        .o_rd_data (win_rd)
    );

    assign link[0] = '{vld: r_feed_vld, val: r_feed_val};

    for (genvar g = 0; g < SORT_N; g++) begin : g_cell
        smf_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (sort_clear),
            .i_in    (link[g]),
            .o_out   (link[g+1]),
            .o_val   (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_width    <= WIDTH_RESET;
            r_seen     <= '0;
            r_pend     <= '0;
            r_last     <= 1'b0;
            r_feed_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_width <= i_window_width;
            if (i_out_ready) r_o_valid <= 1'b0;
            r_feed_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_seen  <= n_seen;
                        r_pend  <= n_pend;
                        r_last  <= i_stream_end;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (emit_go) begin
                        r_off   <= lo_x[IW-1:0];
                        r_hi    <= hi_x[IW-1:0];
                        r_final <= r_last && (back_x == '0);
                        r_k     <= '0;
                        r_state <= ST_FEED;
                    end else begin
                        if (r_last) begin
                            r_seen <= '0;
                            r_pend <= '0;
                            r_last <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_FEED: begin
                    r_feed_vld <= 1'b1;
                    r_feed_val <= win_rd;
                    r_k        <= r_k + 1'b1;
                    r_off      <= r_off + 1'b1;
                    if (r_off == r_hi) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!chain_busy) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_median <= cell_val[mid_idx];
                        r_o_final  <= r_final;
                        r_pend     <= r_pend - 1'b1;
                        r_state    <= ST_CHECK;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_median_value = r_o_median;
    assign o_final_output = r_o_final;

endmodule
